>>> design/psw_pkg.sv
`timescale 1ns / 1ps

package psw_pkg;

	localparam int MAX_JOBS = 16;

	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int ID_W    = 5;
	localparam int TIME_W  = 20;
	localparam int AVG_W   = 28;
	localparam int FRAC_W  = 8;

	localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W = $clog2(MAX_JOBS + 1);

	localparam int ACC_W = (BURST_W + CNT_W > TIME_W) ? BURST_W + CNT_W : TIME_W + 1;
	localparam int SUM_W = ACC_W + CNT_W;
	localparam int DIV_W = SUM_W + FRAC_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic [TIME_W-1:0] sat_time(input logic [ACC_W-1:0] v);
		sat_time = (|v[ACC_W-1:TIME_W]) ? {TIME_W{1'b1}} : v[TIME_W-1:0];
	endfunction

	function automatic logic [AVG_W-1:0] sat_avg(input logic [DIV_W-1:0] v);
		sat_avg = (|v[DIV_W-1:AVG_W]) ? {AVG_W{1'b1}} : v[AVG_W-1:0];
	endfunction

endpackage

>>> design/psw_in_if.sv
`timescale 1ns / 1ps

interface psw_in_if;
	logic                         valid;
	logic                         ready;
	logic [psw_pkg::BURST_W-1:0]  burst_time;
	logic [psw_pkg::PRIO_W-1:0]   priority_req;
	logic                         last_item;

	modport source(output valid, burst_time, priority_req, last_item, input ready);
	modport sink(input valid, burst_time, priority_req, last_item, output ready);
endinterface

>>> design/psw_out_if.sv
`timescale 1ns / 1ps

interface psw_out_if;
	logic                         valid;
	logic                         ready;
	logic [psw_pkg::ID_W-1:0]     job_id;
	logic [psw_pkg::BURST_W-1:0]  job_burst;
	logic [psw_pkg::PRIO_W-1:0]   job_priority;
	logic [psw_pkg::TIME_W-1:0]   waiting_time;
	logic [psw_pkg::TIME_W-1:0]   turnaround_time;
	logic [psw_pkg::AVG_W-1:0]    avg_waiting_fx;
	logic [psw_pkg::AVG_W-1:0]    avg_turnaround_fx;
	logic                         last_result;

	modport source(output valid, job_id, job_burst, job_priority, waiting_time,
		turnaround_time, avg_waiting_fx, avg_turnaround_fx, last_result, input ready);
	modport sink(input valid, job_id, job_burst, job_priority, waiting_time,
		turnaround_time, avg_waiting_fx, avg_turnaround_fx, last_result, output ready);
endinterface

>>> design/psw_ram.sv
`timescale 1ns / 1ps

module psw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/psw_div.sv
`timescale 1ns / 1ps

module psw_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [psw_pkg::DIV_W-1:0]    dividend,
	input  logic [psw_pkg::CNT_W-1:0]    divisor,
	output logic                         done,
	output logic [psw_pkg::DIV_W-1:0]    quotient
);

	logic [psw_pkg::DIV_W-1:0]     quo_q;
	logic [psw_pkg::CNT_W-1:0]     rem_q;
	logic [psw_pkg::CNT_W-1:0]     dsr_q;
	logic [psw_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [psw_pkg::CNT_W:0]       trial;
	logic                          fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[psw_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= psw_pkg::DIV_CNT_W'(psw_pkg::DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - psw_pkg::DIV_CNT_W'(1);
			if (cnt_q == psw_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[psw_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? psw_pkg::CNT_W'(trial - {1'b0, dsr_q}) : trial[psw_pkg::CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> design/priority_schedule_wait_times_unit.sv
`timescale 1ns / 1ps

// channel   dir  payload                                              beat on
// job_in    in   burst_time, priority_req, last_item                  valid & ready
// sched_out out  job_id, job_burst, job_priority, waiting_time,       valid & ready
//                turnaround_time, avg_waiting_fx, avg_turnaround_fx,
//                last_result
//
// one job table ram, kept sorted by priority (stable insertion as jobs arrive)
// a job steps through S_INS (read the entry below its slot) and S_CMP (move that
// entry up if its priority is larger) until its slot is found, and is written there
// emission reads the ram once per result (S_ERD, then S_ECAL); the last one
// waits in S_DIV for the serial average dividers
// arst_n clears the control state; ram content is only read after being written
// sched_out stalls hold the emission sweep; job_in is refused until a batch is out

module priority_schedule_wait_times_unit (
	input  logic              clk,
	input  logic              arst_n,
	psw_in_if.sink            job_in,
	psw_out_if.source         sched_out
);

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_ERD  = 3'd3;
	localparam logic [2:0] S_ECAL = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;

	logic [2:0]                      state_q;
	logic [psw_pkg::IDX_W-1:0]       count_q;
	logic [psw_pkg::IDX_W-1:0]       j_q;
	logic [psw_pkg::IDX_W-1:0]       i_q;
	logic [psw_pkg::CNT_W-1:0]       n_q;
	logic                            last_q;
	psw_pkg::entry_t                 new_q;
	logic [psw_pkg::ACC_W-1:0]       wait_q;
	logic [psw_pkg::SUM_W-1:0]       sum_w_q;
	logic [psw_pkg::SUM_W-1:0]       sum_t_q;

	logic                            ram_we;
	logic                            ram_re;
	logic [psw_pkg::IDX_W-1:0]       ram_waddr;
	logic [psw_pkg::IDX_W-1:0]       ram_raddr;
	psw_pkg::entry_t                 ram_wdata;
	psw_pkg::entry_t                 rd;
	logic [psw_pkg::ENTRY_W-1:0]     rd_bits;

	logic                            in_beat;
	logic                            out_free;
	logic                            out_load;
	logic                            shift;
	logic                            at_last;
	logic [psw_pkg::ACC_W-1:0]       tat_c;
	logic [psw_pkg::SUM_W-1:0]       sum_w_nx;
	logic [psw_pkg::SUM_W-1:0]       sum_t_nx;
	logic [psw_pkg::ID_W-1:0]        id_c;

	logic                            div_start;
	logic                            dw_done;
	logic                            dt_done;
	logic [psw_pkg::DIV_W-1:0]       dw_quo;
	logic [psw_pkg::DIV_W-1:0]       dt_quo;

	logic                            out_valid_q;

	assign rd       = psw_pkg::entry_t'(rd_bits);
	assign in_beat  = job_in.valid & job_in.ready;
	assign out_free = !out_valid_q || sched_out.ready;
	assign shift    = (state_q == S_CMP) && (rd.prio > new_q.prio);
	assign at_last  = {1'b0, i_q} == (n_q - psw_pkg::CNT_W'(1));
	assign out_load = ((state_q == S_ECAL) && !at_last && out_free)
		|| ((state_q == S_DIV) && dw_done && dt_done && out_free);

	assign tat_c    = wait_q + psw_pkg::ACC_W'(rd.burst);
	assign sum_w_nx = sum_w_q + psw_pkg::SUM_W'(wait_q);
	assign sum_t_nx = sum_t_q + psw_pkg::SUM_W'(tat_c);
	assign id_c     = psw_pkg::ID_W'(psw_pkg::CNT_W'(rd.idx) + psw_pkg::CNT_W'(1));

	assign div_start = (state_q == S_ECAL) && at_last;

	always_comb begin
		ram_we    = ((state_q == S_INS) && (j_q == '0)) || (state_q == S_CMP);
		ram_waddr = j_q;
		ram_wdata = shift ? rd : new_q;
		ram_re    = ((state_q == S_INS) && (j_q != '0)) || (state_q == S_ERD);
		ram_raddr = (state_q == S_ERD) ? i_q : j_q - psw_pkg::IDX_W'(1);
	end

	psw_ram #(
		.WIDTH(psw_pkg::ENTRY_W),
		.DEPTH(psw_pkg::MAX_JOBS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_bits)
	);

	psw_div u_div_wait (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_w_nx, {psw_pkg::FRAC_W{1'b0}}}),
		.divisor  (n_q),
		.done     (dw_done),
		.quotient (dw_quo)
	);

	psw_div u_div_tat (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_t_nx, {psw_pkg::FRAC_W{1'b0}}}),
		.divisor  (n_q),
		.done     (dt_done),
		.quotient (dt_quo)
	);

	assign job_in.ready = (state_q == S_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (sched_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_beat) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (j_q == '0) begin
						if (last_q) begin
							count_q <= '0;
							state_q <= S_ERD;
						end else begin
							count_q <= count_q + psw_pkg::IDX_W'(1);
							state_q <= S_LOAD;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (shift) begin
						state_q <= S_INS;
					end else if (last_q) begin
						count_q <= '0;
						state_q <= S_ERD;
					end else begin
						count_q <= count_q + psw_pkg::IDX_W'(1);
						state_q <= S_LOAD;
					end
				end
				S_ERD: begin
					state_q <= S_ECAL;
				end
				S_ECAL: begin
					if (at_last) begin
						state_q <= S_DIV;
					end else if (out_free) begin
						state_q <= S_ERD;
					end
				end
				S_DIV: begin
					if (dw_done && dt_done && out_free) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			new_q.idx   <= count_q;
			new_q.burst <= job_in.burst_time;
			new_q.prio  <= job_in.priority_req;
			last_q      <= job_in.last_item
				|| (count_q == psw_pkg::IDX_W'(psw_pkg::MAX_JOBS - 1));
			j_q         <= count_q;
			n_q         <= psw_pkg::CNT_W'(count_q) + psw_pkg::CNT_W'(1);
			i_q         <= '0;
			wait_q      <= '0;
			sum_w_q     <= '0;
			sum_t_q     <= '0;
		end
		if (shift) begin
			j_q <= j_q - psw_pkg::IDX_W'(1);
		end
		if ((state_q == S_ECAL) && !at_last && out_free) begin
			wait_q  <= tat_c;
			sum_w_q <= sum_w_nx;
			sum_t_q <= sum_t_nx;
			i_q     <= i_q + psw_pkg::IDX_W'(1);
			sched_out.job_id            <= id_c;
			sched_out.job_burst         <= rd.burst;
			sched_out.job_priority      <= rd.prio;
			sched_out.waiting_time      <= psw_pkg::sat_time(wait_q);
			sched_out.turnaround_time   <= psw_pkg::sat_time(tat_c);
			sched_out.avg_waiting_fx    <= '0;
			sched_out.avg_turnaround_fx <= '0;
			sched_out.last_result       <= 1'b0;
		end
		if ((state_q == S_DIV) && dw_done && dt_done && out_free) begin
			sched_out.job_id            <= id_c;
			sched_out.job_burst         <= rd.burst;
			sched_out.job_priority      <= rd.prio;
			sched_out.waiting_time      <= psw_pkg::sat_time(wait_q);
			sched_out.turnaround_time   <= psw_pkg::sat_time(tat_c);
			sched_out.avg_waiting_fx    <= psw_pkg::sat_avg(dw_quo);
			sched_out.avg_turnaround_fx <= psw_pkg::sat_avg(dt_quo);
			sched_out.last_result       <= 1'b1;
		end
	end

	assign sched_out.valid = out_valid_q;

	a_no_back_to_back_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !job_in.ready)
		else $error("job accepted while previous insertion pending");

	a_avg_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(sched_out.valid && !sched_out.last_result)
		|-> (sched_out.avg_waiting_fx == '0 && sched_out.avg_turnaround_fx == '0))
		else $error("average shown on a non-final result");

	a_tat_not_below_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sched_out.valid |-> (sched_out.turnaround_time >= sched_out.waiting_time))
		else $error("turnaround below waiting time");

	a_no_load_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV || state_q == S_ECAL || state_q == S_ERD) |-> (count_q == '0))
		else $error("job count not cleared for emission");

endmodule

>>> sim/tb_priority_schedule_wait_times_unit.sv
`timescale 1ns / 1ps

module tb_priority_schedule_wait_times_unit;
	import psw_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD  = 400;
	localparam int TARGET_JOBS = 310;

	typedef struct packed {
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		logic               last;
		logic [3:0]         gap;
		logic               drain;
	} job_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		logic [TIME_W-1:0]  wait_t;
		logic [TIME_W-1:0]  tat;
		logic [AVG_W-1:0]   avg_wait;
		logic [AVG_W-1:0]   avg_tat;
		logic               last;
	} sched_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	psw_in_if  job_in();
	psw_out_if sched_out();

	priority_schedule_wait_times_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_in    (job_in),
		.sched_out (sched_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	job_item_t  pending_jobs[$];
	sched_rec_t sched_expect_q[$];

	logic [BURST_W-1:0] burst_tbl[MAX_JOBS];
	logic [PRIO_W-1:0]  prio_tbl[MAX_JOBS];
	int unsigned        jobs_loaded = 0;

	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	int unsigned out_beats = 0;
	logic        in_fire = 1'b0;
	logic        out_fire = 1'b0;

	job_item_t   stage_item;
	logic        staged = 1'b0;
	int unsigned tx_wait = 0;

	int unsigned rx_wait = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	function automatic longint unsigned clamp(input longint unsigned v,
		input longint unsigned lim);
		return (v > lim) ? lim : v;
	endfunction

	// stable order by priority: rank counts smaller priorities and earlier ties
	task automatic schedule_job(input logic [BURST_W-1:0] b, input logic [PRIO_W-1:0] p,
		input logic fin);
		int unsigned n;
		int unsigned pos;
		int unsigned order[MAX_JOBS];
		longint unsigned elapsed;
		longint unsigned done_at;
		longint unsigned sum_wait;
		longint unsigned sum_tat;
		sched_rec_t rec;
		if (jobs_loaded >= MAX_JOBS)
			jobs_loaded = 0;
		burst_tbl[jobs_loaded] = b;
		prio_tbl[jobs_loaded] = p;
		jobs_loaded++;
		if (fin || jobs_loaded >= MAX_JOBS) begin
			n = jobs_loaded;
			jobs_loaded = 0;
			for (int i = 0; i < n; i++) begin
				pos = 0;
				for (int j = 0; j < n; j++)
					if (prio_tbl[j] < prio_tbl[i] || (prio_tbl[j] == prio_tbl[i] && j < i))
						pos++;
				order[pos] = i;
			end
			elapsed = 0;
			sum_wait = 0;
			sum_tat = 0;
			for (int k = 0; k < n; k++) begin
				done_at = elapsed + burst_tbl[order[k]];
				rec.id = ID_W'(order[k] + 1);
				rec.burst = burst_tbl[order[k]];
				rec.prio = prio_tbl[order[k]];
				rec.wait_t = TIME_W'(clamp(elapsed, (64'd1 << TIME_W) - 1));
				rec.tat = TIME_W'(clamp(done_at, (64'd1 << TIME_W) - 1));
				rec.avg_wait = '0;
				rec.avg_tat = '0;
				rec.last = 1'b0;
				sum_wait += elapsed;
				sum_tat += done_at;
				elapsed = done_at;
				if (k == n - 1) begin
					rec.last = 1'b1;
					rec.avg_wait = AVG_W'(clamp((sum_wait << FRAC_W) / n,
						(64'd1 << AVG_W) - 1));
					rec.avg_tat = AVG_W'(clamp((sum_tat << FRAC_W) / n,
						(64'd1 << AVG_W) - 1));
				end
				sched_expect_q.push_back(rec);
			end
		end
	endtask

	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	task automatic add_job(input logic [BURST_W-1:0] b, input logic [PRIO_W-1:0] p,
		input logic fin, input int unsigned gap, input logic drain);
		job_item_t it;
		it.burst = b;
		it.prio = p;
		it.last = fin;
		it.gap = 4'(gap);
		it.drain = drain;
		pending_jobs.push_back(it);
	endtask

	// beat sampling, prediction, checking and watchdog
	always @(posedge clk) begin
		sched_rec_t exp_rec;
		in_fire <= arst_n && job_in.valid && job_in.ready;
		out_fire <= arst_n && sched_out.valid && sched_out.ready;
		if (arst_n) begin
			if (job_in.valid && job_in.ready)
				schedule_job(job_in.burst_time, job_in.priority_req, job_in.last_item);
			if (sched_out.valid && sched_out.ready) begin
				out_beats <= out_beats + 1;
				if (sched_expect_q.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with nothing expected, got id %0d",
						$time, sched_out.job_id);
				end else begin
					exp_rec = sched_expect_q.pop_front();
					check_field("job_id", exp_rec.id, sched_out.job_id);
					check_field("job_burst", exp_rec.burst, sched_out.job_burst);
					check_field("job_priority", exp_rec.prio, sched_out.job_priority);
					check_field("waiting_time", exp_rec.wait_t, sched_out.waiting_time);
					check_field("turnaround_time", exp_rec.tat, sched_out.turnaround_time);
					check_field("avg_waiting_fx", exp_rec.avg_wait, sched_out.avg_waiting_fx);
					check_field("avg_turnaround_fx", exp_rec.avg_tat,
						sched_out.avg_turnaround_fx);
					check_field("last_result", exp_rec.last, sched_out.last_result);
				end
			end
			if ((job_in.valid && job_in.ready) || (sched_out.valid && sched_out.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, idle_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// job driver
	always @(negedge clk) begin
		logic v_next;
		if (arst_n && (!job_in.valid || in_fire)) begin
			v_next = 1'b0;
			if (!staged && pending_jobs.size() != 0) begin
				stage_item = pending_jobs.pop_front();
				staged = 1'b1;
				tx_wait = stage_item.gap;
			end
			if (staged) begin
				if (tx_wait != 0)
					tx_wait--;
				else if (!(stage_item.drain && sched_expect_q.size() != 0)) begin
					job_in.burst_time <= stage_item.burst;
					job_in.priority_req <= stage_item.prio;
					job_in.last_item <= stage_item.last;
					v_next = 1'b1;
					staged = 1'b0;
				end
			end
			job_in.valid <= v_next;
		end
	end

	// schedule receiver
	always @(negedge clk) begin
		int unsigned w;
		if (arst_n) begin
			if (!hold_done && out_beats >= 30) begin
				hold_done <= 1'b1;
				hold_left <= LONG_HOLD;
				sched_out.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				sched_out.ready <= 1'b0;
			end else if (out_fire) begin
				w = ((out_beats / 50) % 3 == 2) ? 0 : $urandom_range(0, 11);
				rx_wait <= w;
				sched_out.ready <= (w == 0);
			end else if (rx_wait != 0) begin
				rx_wait <= rx_wait - 1;
				sched_out.ready <= (rx_wait == 1);
			end else begin
				sched_out.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned made;
		int unsigned batch_no;
		int unsigned bsize;
		int unsigned pmode;
		int unsigned bmode;
		int unsigned r;
		logic fill_only;
		logic calm;
		logic [BURST_W-1:0] b;
		logic [PRIO_W-1:0] p;

		job_in.valid = 1'b0;
		job_in.burst_time = '0;
		job_in.priority_req = '0;
		job_in.last_item = 1'b0;
		sched_out.ready = 1'b0;

		// single jobs at both extremes
		add_job(16'h0000, 8'h00, 1'b1, 0, 1'b0);
		add_job(16'hFFFF, 8'hFF, 1'b1, 0, 1'b0);
		// ties keep arrival order
		add_job(16'd5, 8'd3, 1'b0, 0, 1'b0);
		add_job(16'd7, 8'd1, 1'b0, 2, 1'b0);
		add_job(16'd9, 8'd3, 1'b1, 0, 1'b0);
		add_job(16'd1, 8'd128, 1'b0, 3, 1'b1);
		add_job(16'd2, 8'd128, 1'b1, 0, 1'b0);
		// full table without a last mark, reverse priority, max bursts but one of zero
		for (int k = 0; k < MAX_JOBS; k++)
			add_job((k == 5) ? 16'h0000 : 16'hFFFF, 8'((k == MAX_JOBS - 1) ? 0 : 255 - k),
				1'b0, (k < 8) ? 0 : $urandom_range(0, 11), k == 0);
		made = 7 + MAX_JOBS;

		batch_no = 0;
		while (made < TARGET_JOBS) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				bsize = $urandom_range(1, 5);
			else if (r < 8)
				bsize = $urandom_range(6, MAX_JOBS - 1);
			else
				bsize = MAX_JOBS;
			fill_only = (bsize == MAX_JOBS) && $urandom_range(0, 1);
			pmode = $urandom_range(0, 2);
			bmode = $urandom_range(0, 3);
			calm = (batch_no % 5 == 3);
			for (int k = 0; k < bsize; k++) begin
				case (pmode)
					0: p = 8'($urandom_range(0, 255));
					1: p = 8'($urandom_range(0, 3));
					default: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				endcase
				case (bmode)
					0: b = 16'($urandom_range(0, 15));
					1: b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					default: b = 16'($urandom_range(0, 65535));
				endcase
				add_job(b, p, (k == bsize - 1) && !fill_only,
					calm ? 0 : $urandom_range(0, 11),
					(k == 0) && (batch_no == 0 || $urandom_range(0, 7) == 0));
			end
			made += bsize;
			batch_no++;
		end

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_jobs.size() != 0 || staged || job_in.valid
			|| sched_expect_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> priority_schedule_wait_times_unit.f
design/psw_pkg.sv
design/psw_in_if.sv
design/psw_out_if.sv
design/psw_ram.sv
design/psw_div.sv
design/priority_schedule_wait_times_unit.sv
sim/tb_priority_schedule_wait_times_unit.sv
